FILE: rtl/two_level_page_table_manager_assert.svh
// Assertion macros shared by the checker file of the page table manager.
`ifndef TWO_LEVEL_PAGE_TABLE_MANAGER_ASSERT_SVH
`define TWO_LEVEL_PAGE_TABLE_MANAGER_ASSERT_SVH
// Implication checked at every rising edge outside reset.
`define TLPT_ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
// Next-cycle implication checked at every rising edge outside reset.
`define TLPT_ASSERT_NXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

FILE: rtl/tlpt_pkg.sv
// Package of types and constants for the two-level page table manager.
`timescale 1ns / 1ps
package tlpt_pkg;
    localparam logic [1:0] ACT_MAP    = 2'd0;
    localparam logic [1:0] ACT_UNMAP  = 2'd1;
    localparam logic [1:0] ACT_LOOKUP = 2'd2;
    localparam logic [1:0] ACT_FIND   = 2'd3;

    localparam logic [1:0] REG_KBEGIN = 2'd0;
    localparam logic [1:0] REG_KEND   = 2'd1;
    localparam logic [1:0] REG_UBEGIN = 2'd2;
    localparam logic [1:0] REG_UEND   = 2'd3;

    localparam int BIT_PRESENT = 0;
    localparam int BIT_BIG     = 7;
    localparam int TABLE_BITS  = 10;
    localparam int IN_BITS     = 121;
    localparam int IN_BYTES_W  = 128;
    localparam int OUT_W       = 40;

    typedef struct packed {
        logic [1:0]  action;
        logic [25:0] virt;
        logic [31:0] phys;
        logic [11:0] flags;
        logic [31:0] table_frame;
        logic [15:0] pages;
        logic        user;
    } item_t;
endpackage

FILE: rtl/two_level_page_table_manager.sv
// Top level of the two-level page table manager with its sequencer and table memory.
`timescale 1ns / 1ps
// A small sequencer owns a 32-bit directory in flip-flops and a single-port
// table memory with registered reads, one access per cycle. Map on a present
// directory entry, and any word with an address outside the space, pass from
// idle through the read state to the output state; unmap and lookup also pass
// through the use state before the output state. Map on an absent directory
// entry first clears that table, one entry a cycle, and then writes the new
// entry. Find walks the search range: an absent or big directory entry skips
// 4 MB in one step, while a present table is read one page at a time. The
// table memory has no reset; a table becomes readable only after map has
// cleared it.
// s_tdata fields from bit 0: action, virt, phys, flags, table_frame, pages,
// user. m_tdata fields from bit 0: address, mapped, table_used.
module two_level_page_table_manager #(
    parameter int VA_BITS = 26
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,  // action, virt, phys, flags, table_frame, pages, user
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [39:0]  m_tdata,  // address, mapped, table_used
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [25:0]  cfg_data
);
    import tlpt_pkg::*;

    localparam int DIR_BITS  = VA_BITS - 22;
    localparam int DIR_DEPTH = 1 << DIR_BITS;
    localparam int PTE_BITS  = VA_BITS - 12;
    localparam int PTE_DEPTH = 1 << PTE_BITS;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_RD    = 3'd1;
    localparam logic [2:0] S_USE   = 3'd2;
    localparam logic [2:0] S_CLEAR = 3'd3;
    localparam logic [2:0] S_FSTEP = 3'd4;
    localparam logic [2:0] S_FPTE  = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    logic [2:0]  state_reg, state_next;
    logic [31:0] dir_reg [DIR_DEPTH];
    logic [31:0] pte_mem [PTE_DEPTH];
    logic [31:0] rd_reg;
    logic [25:0] kb_reg, ke_reg, ub_reg, ue_reg;
    item_t       it_reg;
    logic [32:0] pg_reg, begin_reg, to_reg;
    logic [16:0] count_reg;
    logic [TABLE_BITS:0] clr_reg;
    logic [31:0] addr_reg;
    logic        mapped_reg, used_reg;

    // Memory port, one access per cycle.
    logic                mem_we, mem_re;
    logic [PTE_BITS-1:0] mem_addr;
    logic [31:0]         mem_wd;

    item_t in_item;
    assign in_item = item_t'({s_tdata[0 +: 2], s_tdata[2 +: 26], s_tdata[28 +: 32],
                              s_tdata[60 +: 12], s_tdata[72 +: 32], s_tdata[104 +: 16],
                              s_tdata[120]});

    logic                va_ok;
    logic [31:0]         virt_w;
    logic [DIR_BITS-1:0] di;
    logic [31:0]         dent;
    assign virt_w = {6'd0, it_reg.virt};
    assign va_ok  = (virt_w >> VA_BITS) == 32'd0;
    assign di     = virt_w[22 +: DIR_BITS];
    assign dent   = dir_reg[di];

    // Search page decode.
    logic                pg_in;
    logic [31:0]         pdent;
    assign pg_in = (pg_reg >> VA_BITS) == 33'd0;
    assign pdent = pg_in ? dir_reg[pg_reg[22 +: DIR_BITS]] : 32'd0;

    logic searching;
    assign searching = ({16'd0, count_reg} < {17'd0, it_reg.pages}) && (begin_reg < to_reg);

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = (state_reg == S_OUT);
    assign m_tdata   = {6'd0, used_reg, mapped_reg, addr_reg};

    always_ff @(posedge clk)
    begin
        if (mem_we)
            pte_mem[mem_addr] <= mem_wd;
        if (mem_re)
            rd_reg <= pte_mem[mem_addr];
    end

    always_comb
    begin
        mem_we   = 1'b0;
        mem_re   = 1'b0;
        mem_addr = virt_w[12 +: PTE_BITS];
        mem_wd   = it_reg.phys | {20'd0, it_reg.flags};
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                    state_next = (in_item.action == ACT_FIND) ? S_FSTEP : S_RD;
            end
            S_RD:
            begin
                if (!va_ok)
                    state_next = S_OUT;
                else if (it_reg.action == ACT_MAP)
                begin
                    if (!dent[BIT_PRESENT])
                        state_next = S_CLEAR;
                    else
                    begin
                        mem_we = 1'b1;
                        state_next = S_OUT;
                    end
                end
                else
                begin
                    mem_re = 1'b1;
                    state_next = S_USE;
                end
            end
            S_USE:
            begin
                if (it_reg.action == ACT_UNMAP && dent[BIT_PRESENT])
                begin
                    mem_we = 1'b1;
                    mem_wd = {rd_reg[31:1], 1'b0};
                end
                state_next = S_OUT;
            end
            S_CLEAR:
            begin
                mem_we = 1'b1;
                if (clr_reg[TABLE_BITS])
                    state_next = S_OUT;
                else
                begin
                    mem_addr = {di, clr_reg[TABLE_BITS-1:0]};
                    mem_wd   = 32'd0;
                end
            end
            S_FSTEP:
            begin
                mem_addr = pg_reg[12 +: PTE_BITS];
                if (!searching)
                    state_next = S_OUT;
                else if (pdent[BIT_PRESENT] && !pdent[BIT_BIG])
                begin
                    mem_re = 1'b1;
                    state_next = S_FPTE;
                end
            end
            S_FPTE:
                state_next = S_FSTEP;
            S_OUT:
            begin
                if (m_tready)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            kb_reg <= '0;
            ke_reg <= '0;
            ub_reg <= '0;
            ue_reg <= '0;
            for (int i = 0; i < DIR_DEPTH; i++)
                dir_reg[i] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    REG_KBEGIN: kb_reg <= cfg_data;
                    REG_KEND:   ke_reg <= cfg_data;
                    REG_UBEGIN: ub_reg <= cfg_data;
                    REG_UEND:   ue_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (state_reg == S_CLEAR && clr_reg[TABLE_BITS])
                dir_reg[di] <= it_reg.table_frame | {20'd0, it_reg.flags};
        end
    end

    // Payload and datapath registers.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                it_reg     <= in_item;
                addr_reg   <= '0;
                mapped_reg <= 1'b0;
                used_reg   <= 1'b0;
                count_reg  <= '0;
                clr_reg    <= '0;
                begin_reg  <= '0;
                pg_reg     <= {7'd0, in_item.user ? ub_reg : kb_reg};
                to_reg     <= {7'd0, in_item.user ? ue_reg : ke_reg};
            end
            S_RD:
            begin
                if (va_ok && it_reg.action == ACT_LOOKUP && dent[BIT_PRESENT] && dent[BIT_BIG])
                begin
                    addr_reg   <= {dent[31:12], 12'd0} | {10'd0, it_reg.virt[21:0]};
                    mapped_reg <= 1'b1;
                end
            end
            S_USE:
            begin
                if (dent[BIT_PRESENT] && it_reg.action == ACT_UNMAP)
                    addr_reg <= {rd_reg[31:12], 12'd0};
                else if (dent[BIT_PRESENT] && !dent[BIT_BIG])
                begin
                    addr_reg   <= {rd_reg[31:12], it_reg.virt[11:0]};
                    mapped_reg <= rd_reg[BIT_PRESENT];
                end
            end
            S_CLEAR:
            begin
                // Once the sweep is done, the clear state writes the new entry itself.
                if (clr_reg[TABLE_BITS])
                    used_reg <= 1'b1;
                else
                    clr_reg <= clr_reg + (TABLE_BITS + 1)'(1);
            end
            S_FSTEP:
            begin
                if (searching)
                begin
                    if (count_reg == 17'd0)
                        begin_reg <= pg_reg;
                    if (!pdent[BIT_PRESENT])
                    begin
                        count_reg <= count_reg + 17'd1024;
                        pg_reg    <= pg_reg + 33'h400000;
                    end
                    else if (pdent[BIT_BIG])
                    begin
                        count_reg <= '0;
                        pg_reg    <= pg_reg + 33'h400000;
                    end
                end
                else
                    addr_reg <= (begin_reg >= to_reg) ? 32'd0 : begin_reg[31:0];
            end
            S_FPTE:
            begin
                count_reg <= rd_reg[BIT_PRESENT] ? 17'd0 : count_reg + 17'd1;
                pg_reg    <= pg_reg + 33'h1000;
            end
            default: ;
        endcase
    end
endmodule

FILE: rtl/tlpt_checker.sv
// Port-level checker for the page table manager and its bind.
`timescale 1ns / 1ps
`include "two_level_page_table_manager_assert.svh"
module tlpt_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic [127:0] s_tdata,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [39:0]  m_tdata
);
    import tlpt_pkg::*;
    `TLPT_ASSERT_IMP(a_excl, clk, rst_n, m_tvalid, !s_tready)
    `TLPT_ASSERT_NXT(a_busy, clk, rst_n, s_tvalid && s_tready, !s_tready && !m_tvalid)
    `TLPT_ASSERT_NXT(a_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    `TLPT_ASSERT_IMP(a_mapped, clk, rst_n, m_tvalid && m_tdata[32], !m_tdata[33])
endmodule

bind two_level_page_table_manager tlpt_checker u_tlpt_checker (.*);

FILE: verif/two_level_page_table_manager_tb.sv
// Self-checking testbench for the two-level page table manager.
`timescale 1ns / 1ps
// The bench drives request words on the slave stream and register writes on the
// configuration channel. A scoreboard object keeps its own copy of the directory,
// the page tables and the heap registers. It works out the reply to every
// accepted request and compares each returned word with the oldest one due.
// The run has four phases, each under different heap ranges. The directed part
// comes first, then random map, lookup, unmap and find requests with some noise.
module two_level_page_table_manager_tb;
    import tlpt_pkg::*;

    localparam int WATCHDOG_LIMIT = 200000;
    localparam int RANDOM_PER_PHASE = 410;

    typedef struct {
        logic [31:0] address;
        logic        mapped;
        logic        table_used;
    } page_reply_t;

    // Scoreboard: a mirror of the page table state, plus the replies still due.
    class page_table_scoreboard;
        logic [31:0] dir_mirror [16];
        logic [31:0] pte_mirror [16384];
        logic [25:0] heap_reg [4];
        page_reply_t due_q [$];
        int errors;
        int replies;
        int finds_hit;

        function new();
            foreach (dir_mirror[i]) dir_mirror[i] = '0;
            foreach (pte_mirror[i]) pte_mirror[i] = '0;
            foreach (heap_reg[i]) heap_reg[i] = '0;
            errors = 0;
            replies = 0;
            finds_hit = 0;
        endfunction

        function void report(string what);
            errors++;
            if (errors <= 30)
                $display("%0t mismatch: %s", $realtime, what);
        endfunction

        // Walks from the start toward the limit, counting free pages.
        function logic [31:0] free_run(int unsigned pages, longint unsigned from_va,
                                       longint unsigned to_va);
            longint unsigned pg;
            longint unsigned run_start;
            int unsigned count;
            logic [31:0] d;
            pg = from_va;
            run_start = 0;
            count = 0;
            while (count < pages && run_start < to_va)
            begin
                if (count == 0)
                    run_start = pg;
                d = (pg < 64'h400_0000) ? dir_mirror[pg[25:22]] : 32'h0;
                if (!d[BIT_PRESENT])
                begin
                    count += 1024;
                    pg += 64'h40_0000;
                end
                else if (d[BIT_BIG])
                begin
                    count = 0;
                    pg += 64'h40_0000;
                end
                else
                begin
                    if (pte_mirror[pg[25:12]][BIT_PRESENT])
                        count = 0;
                    else
                        count++;
                    pg += 64'h1000;
                end
            end
            return (run_start >= to_va) ? 32'h0 : run_start[31:0];
        endfunction

        function void note_request(item_t it);
            page_reply_t r;
            logic [3:0] di;
            logic [13:0] pi;
            logic [31:0] d;
            logic [31:0] e;
            r = '{32'h0, 1'b0, 1'b0};
            di = it.virt[25:22];
            pi = it.virt[25:12];
            d = dir_mirror[di];
            case (it.action)
                ACT_MAP:
                begin
                    if (!d[BIT_PRESENT])
                    begin
                        dir_mirror[di] = it.table_frame | {20'h0, it.flags};
                        for (int i = 0; i < 1024; i++)
                            pte_mirror[{di, i[9:0]}] = '0;
                        r.table_used = 1'b1;
                    end
                    pte_mirror[pi] = it.phys | {20'h0, it.flags};
                end
                ACT_UNMAP:
                begin
                    if (d[BIT_PRESENT])
                    begin
                        r.address = pte_mirror[pi] & 32'hFFFF_F000;
                        pte_mirror[pi][BIT_PRESENT] = 1'b0;
                    end
                end
                ACT_LOOKUP:
                begin
                    if (d[BIT_PRESENT])
                    begin
                        if (d[BIT_BIG])
                        begin
                            r.address = (d & 32'hFFFF_F000) | {10'h0, it.virt[21:0]};
                            r.mapped = 1'b1;
                        end
                        else
                        begin
                            e = pte_mirror[pi];
                            r.address = (e & 32'hFFFF_F000) | {20'h0, it.virt[11:0]};
                            r.mapped = e[BIT_PRESENT];
                        end
                    end
                end
                default:
                begin
                    if (it.user)
                        r.address = free_run(32'(it.pages), 64'(heap_reg[REG_UBEGIN]),
                                             64'(heap_reg[REG_UEND]));
                    else
                        r.address = free_run(32'(it.pages), 64'(heap_reg[REG_KBEGIN]),
                                             64'(heap_reg[REG_KEND]));
                    if (r.address != 0)
                        finds_hit++;
                end
            endcase
            due_q.push_back(r);
        endfunction

        function void check_reply(logic [31:0] address, logic mapped, logic table_used);
            page_reply_t r;
            replies++;
            if (due_q.size() == 0)
            begin
                report($sformatf("reply address %h with nothing due", address));
                return;
            end
            r = due_q.pop_front();
            if (address !== r.address)
                report($sformatf("address %h, wanted %h", address, r.address));
            if (mapped !== r.mapped)
                report($sformatf("mapped %b, wanted %b", mapped, r.mapped));
            if (table_used !== r.table_used)
                report($sformatf("table_used %b, wanted %b", table_used, r.table_used));
        endfunction
    endclass

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [127:0] s_tdata;  // action, virt, phys, flags, table_frame, pages, user
    logic         m_tvalid;
    logic         m_tready;
    logic [39:0]  m_tdata;  // address, mapped, table_used
    logic         cfg_valid;
    logic         cfg_ready;
    logic [1:0]   cfg_index;
    logic [25:0]  cfg_data;

    page_table_scoreboard sb;
    int idle_cycles;
    int hold_request;
    int words_sent;
    logic [25:0] virt_pool [$];

    two_level_page_table_manager dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Result side: short random stalls, the odd long one, and a long hold-off
    // when the main sequence asks for one.
    initial
    begin
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left = 0;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_request > 0)
            begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                if ($urandom_range(0, 5) == 0)
                    stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 60)
                                                             : $urandom_range(1, 3);
            end
        end
    end

    // Every accepted reply is checked against the oldest one due.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_reply(m_tdata[31:0], m_tdata[32], m_tdata[33]);
    end

    // Watchdog: counts cycles in which neither stream nor the register port moves.
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
            || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog expired with %0d replies due", sb.due_q.size());
            $display("[two_level_page_table_manager] ERROR");
            $finish;
        end
    end

    // Offers one request word and returns once it is accepted, then, when gaps are
    // allowed, sometimes idles for a random gap. With no gap, valid simply stays high for the next word.
    task send_request(item_t it, bit allow_gap);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata <= {7'h0, it.user, it.pages, it.table_frame, it.flags, it.phys,
                    it.virt, it.action};
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_request(it);
        words_sent++;
        gap = 0;
        if (allow_gap && $urandom_range(0, 3) == 0)
            gap = ($urandom_range(0, 11) == 0) ? $urandom_range(10, 40)
                                                : $urandom_range(1, 3);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.due_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    // Writes one register; valid is left high so that writes can run back to back.
    task write_reg(logic [1:0] idx, logic [25:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.heap_reg[idx] = value;
    endtask

    task set_heaps(logic [25:0] kb, logic [25:0] ke, logic [25:0] ub, logic [25:0] ue);
        write_reg(REG_KBEGIN, kb);
        write_reg(REG_KEND, ke);
        write_reg(REG_UBEGIN, ub);
        write_reg(REG_UEND, ue);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic item_t make_item(logic [1:0] act, logic [25:0] va, logic [11:0] fl);
        item_t it;
        it.action = act;
        it.virt = va;
        it.phys = $urandom();
        it.flags = fl;
        it.table_frame = $urandom();
        it.pages = 16'($urandom_range(1, 24));
        it.user = 1'($urandom_range(0, 1));
        return it;
    endfunction

    // Random request: maps, lookups and unmaps, mostly with the present bit and
    // of addresses already used; some finds and some plain noise.
    function automatic item_t random_item();
        item_t it;
        int pick;
        logic [25:0] va;
        logic [11:0] fl;
        fl = 12'($urandom());
        fl[BIT_PRESENT] = ($urandom_range(0, 9) != 0);
        fl[BIT_BIG] = ($urandom_range(0, 11) == 0);
        if (virt_pool.size() != 0 && $urandom_range(0, 9) < 7)
            va = virt_pool[$urandom_range(0, virt_pool.size() - 1)];
        else
            va = 26'($urandom());
        // Sometimes the page offset is made random, keeping the same page.
        if ($urandom_range(0, 3) == 0)
            va[11:0] = 12'($urandom());
        pick = $urandom_range(0, 99);
        if (pick < 34)
            it = make_item(ACT_MAP, va, fl);
        else if (pick < 64)
            it = make_item(ACT_LOOKUP, va, fl);
        else if (pick < 84)
            it = make_item(ACT_UNMAP, va, fl);
        else if (pick < 92)
        begin
            it = make_item(ACT_FIND, va, fl);
            if ($urandom_range(0, 15) == 0)
                it.pages = 16'($urandom());
            else if ($urandom_range(0, 9) == 0)
                it.pages = 0;
        end
        else
            it = make_item(2'($urandom_range(0, 3)), 26'($urandom()), 12'($urandom()));
        if (it.action == ACT_MAP)
        begin
            virt_pool.push_back(it.virt);
            if (virt_pool.size() > 48)
                void'(virt_pool.pop_front());
        end
        return it;
    endfunction

    function automatic logic [25:0] random_heap_reg();
        case ($urandom_range(0, 3))
            0: return 26'h0;
            1: return 26'h3FF_FFFF;
            default: return 26'($urandom());
        endcase
    endfunction

    initial
    begin
        item_t it;
        sb = new();
        idle_cycles = 0;
        hold_request = 0;
        words_sent = 0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_KBEGIN;
        cfg_data = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Phase one: the full space for kernel requests, a middle window for user.
        set_heaps(26'h0, 26'h3FF_FFFF, 26'h080_0000, 26'h100_0000);

        // Directed part. A find on an empty table, then the field extremes.
        send_request(make_item(ACT_FIND, 26'h0, 12'h0), 1'b0);
        it = make_item(ACT_FIND, 26'h0, 12'h0);
        it.pages = 0;
        send_request(it, 1'b0);
        it = make_item(ACT_LOOKUP, 26'h123_4567, 12'h0);
        send_request(it, 1'b0);                            // absent directory entry
        send_request(make_item(ACT_UNMAP, 26'h123_4567, 12'h0), 1'b0);
        it = make_item(ACT_MAP, 26'h0, 12'h001);
        it.phys = 32'hFFFF_F000;
        send_request(it, 1'b0);                            // installs a new table
        send_request(make_item(ACT_LOOKUP, 26'h0_0ABC, 12'h0), 1'b0);
        it = make_item(ACT_MAP, 26'h3FF_FFFF, 12'hFFF);
        it.phys = 32'hFFFF_FFFF;
        it.table_frame = 32'hFFFF_FFFF;
        send_request(it, 1'b0);                            // big page directory entry
        send_request(make_item(ACT_LOOKUP, 26'h3FF_FFFF, 12'h0), 1'b0);
        send_request(make_item(ACT_LOOKUP, 26'h3C0_0000, 12'h0), 1'b0);
        send_request(make_item(ACT_MAP, 26'h3C0_1000, 12'h003), 1'b0);
        send_request(make_item(ACT_UNMAP, 26'h3C0_1000, 12'h0), 1'b0);
        it = make_item(ACT_MAP, 26'h040_2000, 12'h000);
        it.table_frame = 32'h0;
        it.phys = 32'h0;
        send_request(it, 1'b0);                            // directory stays absent
        send_request(make_item(ACT_MAP, 26'h040_3000, 12'h001), 1'b0);
        send_request(make_item(ACT_LOOKUP, 26'h040_3FFF, 12'h0), 1'b0);
        send_request(make_item(ACT_UNMAP, 26'h0_0000, 12'h0), 1'b0);
        send_request(make_item(ACT_LOOKUP, 26'h0_0000, 12'h0), 1'b0);
        send_request(make_item(ACT_UNMAP, 26'h0_0000, 12'h0), 1'b0);
        it = make_item(ACT_FIND, 26'h0, 12'h0);
        it.user = 1'b0;
        it.pages = 16'd1500;
        send_request(it, 1'b0);
        it.user = 1'b1;
        it.pages = 16'hFFFF;
        send_request(it, 1'b0);
        it.user = 1'b0;
        it.pages = 16'd3;
        send_request(it, 1'b0);

        for (int phase = 0; phase < 4; phase++)
        begin
            if (phase == 1)
                set_heaps(random_heap_reg(), random_heap_reg(), 26'($urandom()),
                          26'($urandom()));
            else if (phase == 2)
                set_heaps(26'h3FF_FFFF, 26'h0, 26'h0A0_0000, 26'h0A0_0000);
            else if (phase == 3)
                set_heaps(26'($urandom_range(0, 26'h1FF_FFFF)), 26'h3FF_FFFF,
                          26'h0, 26'($urandom()));
            for (int n = 0; n < RANDOM_PER_PHASE; n++)
            begin
                // Some stretches run without any sender gaps.
                send_request(random_item(), (n % 100) >= 30);
                if (phase == 1 && n == 50)
                    hold_request = 400;
                if (phase == 2 && n == 200)
                begin
                    s_tvalid <= 1'b0;
                    @(posedge clk);
                    while (sb.due_q.size() != 0)
                        @(posedge clk);
                end
            end
            drain();
        end

        $display("Sent %0d requests and checked %0d replies over four heap settings.",
                 words_sent, sb.replies);
        $display("Covered map, unmap, lookup and free-run search; %0d searches found a run.",
                 sb.finds_hit);
        if (sb.errors == 0 && sb.due_q.size() == 0)
            $display("[two_level_page_table_manager] OK");
        else
            $display("[two_level_page_table_manager] ERROR");
        $finish;
    end
endmodule

FILE: files.f
+incdir+rtl
rtl/tlpt_pkg.sv
rtl/two_level_page_table_manager.sv
rtl/tlpt_checker.sv
verif/two_level_page_table_manager_tb.sv
